>>> rtl/dhcr_pkg.sv
`timescale 1ns / 1ps

package dhcr_pkg;

	// Fixed field widths
	localparam int SECONDS_BITS   = 8;
	localparam int REF_BITS       = 8;
	localparam int READ_BITS      = 16;
	localparam int SLOT_BITS      = 3;
	localparam int CFG_INDEX_BITS = 2;

	// Threshold reset values
	localparam int HIGH_THRESHOLD_RESET = 768;
	localparam int LOW_THRESHOLD_RESET  = 256;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_THRESHOLD  = 2'd1;

	// Reference to slot mapping: slot = (ref - 1) xor 1, low three bits
	localparam logic [REF_BITS-1:0]  REF_ONE      = 8'h01;
	localparam logic [SLOT_BITS-1:0] SLOT_CH_FLIP = 3'h1;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_READ   = 1'b1
	} opcode_t;

	// Upper two slot bits pick the word kind, the low bit the channel
	typedef enum logic [1:0] {
		GRP_RAW   = 2'd0,
		GRP_COUNT = 2'd1,
		GRP_RATE  = 2'd2,
		GRP_SNAP  = 2'd3
	} word_grp_t;

endpackage

>>> rtl/dual_hysteresis_crossing_rate_counter.sv
`timescale 1ns / 1ps
// Order: a read request passes through stage 1 and the channel-store read registers into
// the output register; a sample updates the channel store from stage 1.
// Throughput: one request per cycle unless a read waits on a full, stalled output; the
// channel store is read-modify-write, write-first forwarded to a request reading that entry.
// Reset: all counters, rates, snapshots, raw samples, channel and seconds clear to zero;
// thresholds return to 768 and 256. No clearing pass.
module dual_hysteresis_crossing_rate_counter import dhcr_pkg::*; #(
	parameter int SAMPLE_BITS = 10,
	parameter int COUNT_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]    cfg_data,
	// request channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      opcode,
	input  logic [SAMPLE_BITS-1:0]    sample,
	input  logic [SECONDS_BITS-1:0]   seconds_now,
	input  logic [REF_BITS-1:0]       read_reference,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [READ_BITS-1:0]      read_value
);

	localparam int WORD_BITS = SAMPLE_BITS + COUNT_BITS;

	// Thresholds
	logic [SAMPLE_BITS-1:0] high_q;
	logic [SAMPLE_BITS-1:0] low_q;

	// Front-end state
	logic                    ch_q;
	logic [SECONDS_BITS-1:0] last_sec_q;

	// Stage 1
	logic                   valid_s1;
	logic                   op_s1;
	logic                   ch_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SLOT_BITS-1:0]   slot_s1;
	logic                   sec_evt_s1;

	// Per-channel rate and snapshot
	logic [COUNT_BITS-1:0] rate_q [2];
	logic [COUNT_BITS-1:0] snap_q [2];

	// Output register
	logic                 out_valid_q;
	logic [READ_BITS-1:0] read_value_q;

	logic                   in_go;
	logic                   hold;
	logic [SLOT_BITS-1:0]   slot_in;
	logic                   rd_ch;
	logic                   wr_en;
	logic [WORD_BITS-1:0]   wr_data;
	logic [WORD_BITS-1:0]   word_a;
	logic [WORD_BITS-1:0]   word_b;
	logic [COUNT_BITS-1:0]  cnt_a;
	logic [COUNT_BITS-1:0]  cnt_b;
	logic [SAMPLE_BITS-1:0] raw_a;
	logic                   step;
	logic [COUNT_BITS-1:0]  cnt_new;
	logic [COUNT_BITS-1:0]  cnt_ch [2];
	logic [READ_BITS-1:0]   rd_word;

	// Configuration writes, unknown indexes ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= SAMPLE_BITS'(HIGH_THRESHOLD_RESET);
			low_q  <= SAMPLE_BITS'(LOW_THRESHOLD_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HIGH_THRESHOLD: high_q <= cfg_data;
				REG_LOW_THRESHOLD:  low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Only a read waiting on a full, stalled output blocks the pipe
	assign hold     = valid_s1 && (op_s1 == OP_READ) && out_valid_q && out_stall;
	assign in_stall = hold;
	assign in_go    = in_valid && !in_stall;

	// Request decode
	assign slot_in = SLOT_BITS'(read_reference - REF_ONE) ^ SLOT_CH_FLIP;
	assign rd_ch   = (opcode == OP_READ) ? slot_in[0] : ch_q;

	// Channel toggle and seconds tracking at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q       <= 1'b0;
			last_sec_q <= '0;
		end else if (in_go && (opcode == OP_SAMPLE)) begin
			ch_q       <= ~ch_q;
			last_sec_q <= seconds_now;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_go) begin
			op_s1      <= opcode;
			ch_s1      <= rd_ch;
			sample_s1  <= sample;
			slot_s1    <= slot_in;
			sec_evt_s1 <= (seconds_now != last_sec_q);
		end
	end

	// Channel store
	dhcr_state_mem #(
		.WORD_BITS(WORD_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_go),
		.rd_addr   (rd_ch),
		.wr_en     (wr_en),
		.wr_addr   (ch_s1),
		.wr_data   (wr_data),
		.rd_data_a (word_a),
		.rd_data_b (word_b)
	);

	assign cnt_a = word_a[COUNT_BITS-1:0];
	assign raw_a = word_a[WORD_BITS-1:COUNT_BITS];
	assign cnt_b = word_b[COUNT_BITS-1:0];

	// Hysteresis: even count waits for high crossing, odd for low crossing
	assign step    = cnt_a[0] ? (sample_s1 < low_q) : (sample_s1 > high_q);
	assign cnt_new = cnt_a + COUNT_BITS'(step);
	assign wr_en   = valid_s1 && (op_s1 == OP_SAMPLE);
	assign wr_data = {sample_s1, cnt_new};

	// Counts of both channels after this sample
	assign cnt_ch[0] = ch_s1 ? cnt_b : cnt_new;
	assign cnt_ch[1] = ch_s1 ? cnt_new : cnt_b;

	// Rate latch on a seconds change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q[0] <= '0;
			rate_q[1] <= '0;
			snap_q[0] <= '0;
			snap_q[1] <= '0;
		end else if (wr_en && sec_evt_s1) begin
			for (int c = 0; c < 2; c++) begin
				rate_q[c] <= cnt_ch[c] - snap_q[c];
				snap_q[c] <= cnt_ch[c];
			end
		end
	end

	// Word select for reads; store port A holds the slot's channel
	always_comb begin
		unique case (word_grp_t'(slot_s1[SLOT_BITS-1:1]))
			GRP_RAW:   rd_word = READ_BITS'(raw_a);
			GRP_COUNT: rd_word = READ_BITS'(cnt_a);
			GRP_RATE:  rd_word = READ_BITS'(rate_q[slot_s1[0]]);
			GRP_SNAP:  rd_word = READ_BITS'(snap_q[slot_s1[0]]);
			default:   rd_word = '0;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && (op_s1 == OP_READ) && !hold) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && (op_s1 == OP_READ) && !hold) begin
			read_value_q <= rd_word;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;

endmodule

>>> rtl/dhcr_state_mem.sv
`timescale 1ns / 1ps

// Two-entry per-channel store {raw, count}; two registered read ports
// (selected entry and the other one), write-first forwarding.
module dhcr_state_mem import dhcr_pkg::*; #(
	parameter int WORD_BITS = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic                 rd_addr,
	input  logic                 wr_en,
	input  logic                 wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	output logic [WORD_BITS-1:0] rd_data_a,
	output logic [WORD_BITS-1:0] rd_data_b
);

	logic [WORD_BITS-1:0] mem_q [2];
	logic [1:0]           vld_q;
	logic [WORD_BITS-1:0] rd_a_q;
	logic [WORD_BITS-1:0] rd_b_q;
	logic                 oth_addr;

	assign oth_addr = ~rd_addr;

	// Storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Read ports, same-edge write forwarded; data held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_a_q <= wr_data;
			end else begin
				rd_a_q <= vld_q[rd_addr] ? mem_q[rd_addr] : '0;
			end
			if (wr_en && (wr_addr == oth_addr)) begin
				rd_b_q <= wr_data;
			end else begin
				rd_b_q <= vld_q[oth_addr] ? mem_q[oth_addr] : '0;
			end
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule
